// ===== sv/dlc_pkg.sv =====
package dlc_pkg;

  localparam int COORD_BITS  = 16;
  localparam int RADIUS_BITS = 14;
  localparam int COUNT_BITS  = 30;

  localparam int MAX_IN_BITS = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
  localparam int WIDE_BITS   = MAX_IN_BITS + 2;
  localparam int ERR_BITS    = RADIUS_BITS + 3;
  localparam int SUM_BITS    = ((COUNT_BITS > WIDE_BITS) ? COUNT_BITS : WIDE_BITS) + 1;

  typedef logic [WIDE_BITS-1:0] wide_t;

  typedef struct packed {
    wide_t left;
    wide_t bottom;
    wide_t right;
    wide_t top;
  } rect_t;

  typedef struct packed {
    logic  clr;
    logic  add;
    wide_t len;
  } acc_ctl_t;

endpackage

// ===== sv/dlc_clip.sv =====
module dlc_clip
  import dlc_pkg::*;
(
  input  rect_t rect,
  input  wide_t col,
  input  wide_t lo,
  input  wide_t hi,
  output wide_t len
);

  logic  in_rect;
  wide_t span_top;
  wide_t span_bot;
  wide_t diff;

  always_comb begin
    in_rect = ($signed(col) >= $signed(rect.left)) && ($signed(col) <= $signed(rect.right)) &&
              ($signed(lo) <= $signed(rect.top)) && ($signed(hi) >= $signed(rect.bottom));
    span_top = ($signed(hi) < $signed(rect.top)) ? hi : rect.top;
    span_bot = ($signed(lo) > $signed(rect.bottom)) ? lo : rect.bottom;
    diff = span_top - span_bot;
    len = (in_rect && !diff[WIDE_BITS-1]) ? diff + wide_t'(1) : '0;
  end

endmodule

// ===== sv/dlc_accum.sv =====
module dlc_accum
  import dlc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  acc_ctl_t              ctl,
  output logic [COUNT_BITS-1:0] total
);

  logic                len_q;
  wide_t               len_val;
  logic [SUM_BITS-1:0] sum;

  assign sum = SUM_BITS'(total) + SUM_BITS'(len_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      len_q <= 1'b0;
    end else begin
      len_q <= ctl.add;
    end
    len_val <= ctl.len;
    if (ctl.clr) begin
      total <= '0;
    end else if (len_q) begin
      if (sum[SUM_BITS-1:COUNT_BITS] != '0) begin
        total <= '1;
      end else begin
        total <= sum[COUNT_BITS-1:0];
      end
    end
  end

endmodule

// ===== sv/disc_rect_lattice_count.sv =====
// Counts the integer lattice points that lie inside or on a circle and inside
// an inclusive axis-aligned rectangle.
// Input channel: in_valid / in_ready with the rectangle corners, circle center
// and radius. Output channel: out_valid / out_ready with point_count.
// One item is in flight at a time; in_ready is high only while the sequencer
// is idle. The walk steps a column counter from the center outward and keeps
// the half-height with an incremental error term, one add per cycle; each
// mirrored column span is clipped by one shared clip unit and summed.
// The walk always ends at half-height zero, so the number of half-height
// decrements equals the radius.
// The result sits in an output register: a new item is accepted while it
// waits, but the next result is held back until the receiver takes the old
// one. A stalled receiver therefore stalls the block only at its last step.
// Reset (rst, synchronous) returns the sequencer to idle and drops any
// pending result.
module disc_rect_lattice_count
  import dlc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_BITS-1:0]  rect_left,
  input  logic [COORD_BITS-1:0]  rect_bottom,
  input  logic [COORD_BITS-1:0]  rect_right,
  input  logic [COORD_BITS-1:0]  rect_top,
  input  logic [COORD_BITS-1:0]  center_x,
  input  logic [COORD_BITS-1:0]  center_y,
  input  logic [RADIUS_BITS-1:0] radius,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COUNT_BITS-1:0]  point_count
);

  typedef enum logic [2:0] {
    S_IDLE, S_CENTER, S_ADV, S_DEC, S_SPAN_P, S_SPAN_N, S_FLUSH, S_FINISH
  } state_t;

  state_t                 state;
  rect_t                  rect;
  logic [RADIUS_BITS-1:0] rad;
  logic [RADIUS_BITS-1:0] dx;
  logic [RADIUS_BITS-1:0] h;
  logic [ERR_BITS-1:0]    err;
  wide_t                  lo;
  wide_t                  hi;
  wide_t                  colp;
  wide_t                  coln;

  logic                   accept;
  logic                   result_load;
  logic [RADIUS_BITS-1:0] dx_next;
  logic [ERR_BITS-1:0]    err_adv;
  logic [ERR_BITS-1:0]    err_dec;
  logic                   err_pos;
  wide_t                  cx_w;
  wide_t                  cy_w;
  wide_t                  rad_w;
  wide_t                  clip_col;
  wide_t                  clip_len;
  acc_ctl_t               acc_ctl;
  logic [COUNT_BITS-1:0]  total;

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign result_load = (state == S_FINISH) && (!out_valid || out_ready);

  assign cx_w  = {{(WIDE_BITS-COORD_BITS){center_x[COORD_BITS-1]}}, center_x};
  assign cy_w  = {{(WIDE_BITS-COORD_BITS){center_y[COORD_BITS-1]}}, center_y};
  assign rad_w = {{(WIDE_BITS-RADIUS_BITS){1'b0}}, radius};

  assign dx_next = dx + RADIUS_BITS'(1);
  assign err_adv = err + {2'b00, dx, 1'b1};
  assign err_dec = err + ERR_BITS'(1) - {2'b00, h, 1'b0};
  assign err_pos = !err[ERR_BITS-1] && (err != '0);

  assign clip_col = (state == S_SPAN_N) ? coln : colp;

  dlc_clip u_clip (
    .rect (rect),
    .col  (clip_col),
    .lo   (lo),
    .hi   (hi),
    .len  (clip_len)
  );

  always_comb begin
    acc_ctl.clr = accept;
    acc_ctl.add = (state == S_CENTER) || (state == S_SPAN_P) || (state == S_SPAN_N);
    acc_ctl.len = clip_len;
  end

  dlc_accum u_accum (
    .clk   (clk),
    .rst   (rst),
    .ctl   (acc_ctl),
    .total (total)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            rect.left   <= {{(WIDE_BITS-COORD_BITS){rect_left[COORD_BITS-1]}}, rect_left};
            rect.bottom <= {{(WIDE_BITS-COORD_BITS){rect_bottom[COORD_BITS-1]}}, rect_bottom};
            rect.right  <= {{(WIDE_BITS-COORD_BITS){rect_right[COORD_BITS-1]}}, rect_right};
            rect.top    <= {{(WIDE_BITS-COORD_BITS){rect_top[COORD_BITS-1]}}, rect_top};
            rad   <= radius;
            dx    <= '0;
            h     <= radius;
            err   <= '0;
            lo    <= cy_w - rad_w;
            hi    <= cy_w + rad_w;
            colp  <= cx_w;
            coln  <= cx_w;
            state <= S_CENTER;
          end
        end
        S_CENTER: begin
          state <= (rad == '0) ? S_FLUSH : S_ADV;
        end
        S_ADV: begin
          dx    <= dx_next;
          err   <= err_adv;
          colp  <= colp + wide_t'(1);
          coln  <= coln - wide_t'(1);
          state <= S_DEC;
        end
        S_DEC: begin
          if ((h != '0) && err_pos) begin
            h   <= h - RADIUS_BITS'(1);
            err <= err_dec;
            lo  <= lo + wide_t'(1);
            hi  <= hi - wide_t'(1);
          end else begin
            state <= S_SPAN_P;
          end
        end
        S_SPAN_P: begin
          state <= S_SPAN_N;
        end
        S_SPAN_N: begin
          state <= (dx == rad) ? S_FLUSH : S_ADV;
        end
        S_FLUSH: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (result_load) begin
            point_count <= total;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/dlc_checker.sv =====
module dlc_checker
  import dlc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COUNT_BITS-1:0] point_count
);

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accepted item");

  // a result appears only as the walk ends and the block goes idle
  a_result_ends_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready && $past(!in_ready))
    else $error("result appeared outside the end of a walk");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_count))
    else $error("stalled result changed or dropped");

  // out_valid does not rise right after an accepted item
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result one cycle after accept");

endmodule

bind disc_rect_lattice_count dlc_checker u_dlc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .point_count (point_count)
);
